### rtl/clm_pkg.sv
// clm_pkg: shared constants, command, status and state types for the circular list manager
// depends on nothing; imported by circular_list_manager_unit and clm_ram users
package clm_pkg;

  localparam int NODES  = 256;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);

  typedef enum logic [2:0] {
    CMD_INS_AFTER  = 3'd0,
    CMD_INS_BEFORE = 3'd1,
    CMD_APPEND     = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_GET        = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ALREADY = 3'd1,
    ST_ANCHOR  = 3'd2,
    ST_NOTMEM  = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR1,
    S_WR2,
    S_WALK,
    S_OUT
  } state_t;

endpackage

### rtl/clm_ram.sv
// clm_ram: simple dual-port synchronous ram, one write and one registered read per cycle
// generic storage for the link tables; no package dependency
module clm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/circular_list_manager_unit.sv
// circular_list_manager_unit: circular doubly linked list over a fixed pool of node handles
// uses clm_pkg and two clm_ram instances for the next and previous link tables
//
// usage
//   in channel  : one command per transfer (insert after/before, append, remove, get, clear)
//   out channel : exactly one result per command, in command order
//   states a command passes through after it is taken, up to the result load in S_OUT:
//     insert after / insert before / append to a non-empty list : S_WR1, S_WR2, S_OUT
//     remove of one of several nodes                              : S_WR1, S_OUT
//     get at position p > 0                                       : S_WALK (one link read a step), S_OUT
//     everything else (clear, errors, get at 0, first append)     : S_OUT
//   the two write states come from the single write port of each link ram: an insert writes four
//   links, two per cycle; a get follows next links one registered read per cycle
//   membership flags sit in flip-flops, so clear drops every member at once
//   a command is taken only when the sequencer is idle; the previous result may still sit in
//   the output register, and a finished command waits there until the receiver drains it
//   reset (rst_n low, synchronous) empties the list and drops any pending result; link ram
//   content is left as is and is never read before it is written
module circular_list_manager_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] cmd, [10:3] node_handle, [18:11] new_node_handle, [26:19] position, [31:27] zero
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [10:3] found_node, [19:11] count_now, [27:20] head_node,
  // [28] list_empty, [31:29] zero
  output logic [31:0] out_tdata
);

  import clm_pkg::*;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [NODE_W-1:0]    nh_r, nn_r;
  logic [NODE_W-1:0]    walk_cnt_r, walk_cnt_nxt;
  status_t              status_r, status_nxt;
  logic [NODE_W-1:0]    found_r, found_nxt;
  logic [NODE_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [NODES-1:0]     member_r, member_nxt;
  logic                 out_valid_r;
  logic [31:0]          out_data_r;

  cmd_t                 in_cmd;
  logic [NODE_W-1:0]    in_nh, in_nn, in_pos;
  logic                 in_fire, out_free, out_load;
  logic [31:0]          out_word;

  logic                 nxt_we, nxt_re, prv_we, prv_re;
  logic [NODE_W-1:0]    nxt_waddr, nxt_wdata, nxt_raddr, nxt_rd;
  logic [NODE_W-1:0]    prv_waddr, prv_wdata, prv_raddr, prv_rd;
  logic [NODE_W-1:0]    ins_node, link_a, link_b;

  assign in_cmd    = cmd_t'(in_tdata[2:0]);
  assign in_nh     = in_tdata[10:3];
  assign in_nn     = in_tdata[18:11];
  assign in_pos    = in_tdata[26:19];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  clm_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (nxt_re),
    .raddr (nxt_raddr),
    .rdata (nxt_rd)
  );

  clm_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (prv_re),
    .raddr (prv_raddr),
    .rdata (prv_rd)
  );

  // new node goes between link_a and link_b; before and append read prev only, since
  // next of prev of x is x itself
  always_comb begin
    ins_node = (cmd_r == CMD_APPEND) ? nh_r : nn_r;
    link_a   = prv_rd;
    link_b   = head_r;
    case (cmd_r)
      CMD_INS_AFTER: begin
        link_a = nh_r;
        link_b = nxt_rd;
      end
      CMD_INS_BEFORE: begin
        link_a = prv_rd;
        link_b = nh_r;
      end
      default: begin
        link_a = prv_rd;
        link_b = head_r;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    walk_cnt_nxt = walk_cnt_r;
    status_nxt   = status_r;
    found_nxt    = found_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    member_nxt   = member_r;
    out_load     = 1'b0;
    nxt_we       = 1'b0;
    nxt_waddr    = ins_node;
    nxt_wdata    = link_b;
    nxt_re       = 1'b0;
    nxt_raddr    = in_nh;
    prv_we       = 1'b0;
    prv_waddr    = ins_node;
    prv_wdata    = link_a;
    prv_re       = 1'b0;
    prv_raddr    = in_nh;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          status_nxt = ST_OK;
          found_nxt  = '0;
          state_nxt  = S_OUT;
          unique case (in_cmd) inside
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (member_r[in_nn]) begin
                status_nxt = ST_ALREADY;
              end else if (!member_r[in_nh]) begin
                status_nxt = ST_ANCHOR;
              end else begin
                if (in_cmd == CMD_INS_AFTER) begin
                  nxt_re = 1'b1;
                end else begin
                  prv_re = 1'b1;
                end
                state_nxt = S_WR1;
              end
            end
            CMD_APPEND: begin
              if (member_r[in_nh]) begin
                status_nxt = ST_ALREADY;
              end else if (count_r == '0) begin
                // first node links to itself
                nxt_we            = 1'b1;
                nxt_waddr         = in_nh;
                nxt_wdata         = in_nh;
                prv_we            = 1'b1;
                prv_waddr         = in_nh;
                prv_wdata         = in_nh;
                member_nxt[in_nh] = 1'b1;
                head_nxt          = in_nh;
                count_nxt         = CNT_W'(1);
              end else begin
                prv_re    = 1'b1;
                prv_raddr = head_r;
                state_nxt = S_WR1;
              end
            end
            CMD_REMOVE: begin
              if (!member_r[in_nh] || count_r == '0) begin
                status_nxt = ST_NOTMEM;
              end else if (count_r == CNT_W'(1)) begin
                member_nxt[in_nh] = 1'b0;
                head_nxt          = '0;
                count_nxt         = '0;
              end else begin
                nxt_re    = 1'b1;
                prv_re    = 1'b1;
                state_nxt = S_WR1;
              end
            end
            CMD_GET: begin
              if ({1'b0, in_pos} >= count_r) begin
                status_nxt = ST_RANGE;
              end else if (in_pos == '0) begin
                found_nxt = head_r;
              end else begin
                nxt_re       = 1'b1;
                nxt_raddr    = head_r;
                walk_cnt_nxt = in_pos - NODE_W'(1);
                state_nxt    = S_WALK;
              end
            end
            CMD_CLEAR: begin
              member_nxt = '0;
              head_nxt   = '0;
              count_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_WR1: begin
        if (cmd_r == CMD_REMOVE) begin
          // splice prev and next of the removed node together
          nxt_we           = 1'b1;
          nxt_waddr        = prv_rd;
          nxt_wdata        = nxt_rd;
          prv_we           = 1'b1;
          prv_waddr        = nxt_rd;
          prv_wdata        = prv_rd;
          member_nxt[nh_r] = 1'b0;
          if (head_r == nh_r) begin
            head_nxt = nxt_rd;
          end
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_OUT;
        end else begin
          nxt_we               = 1'b1;
          prv_we               = 1'b1;
          member_nxt[ins_node] = 1'b1;
          state_nxt            = S_WR2;
        end
      end
      S_WR2: begin
        nxt_we    = 1'b1;
        nxt_waddr = link_a;
        nxt_wdata = ins_node;
        prv_we    = 1'b1;
        prv_waddr = link_b;
        prv_wdata = ins_node;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      S_WALK: begin
        if (walk_cnt_r == '0) begin
          found_nxt = nxt_rd;
          state_nxt = S_OUT;
        end else begin
          nxt_re       = 1'b1;
          nxt_raddr    = nxt_rd;
          walk_cnt_nxt = walk_cnt_r - NODE_W'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word        = '0;
    out_word[2:0]   = status_r;
    out_word[10:3]  = found_r;
    out_word[19:11] = count_r;
    out_word[27:20] = (count_r == '0) ? '0 : head_r;
    out_word[28]    = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      member_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      member_r <= member_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd;
      nh_r  <= in_nh;
      nn_r  <= in_nn;
    end
    walk_cnt_r <= walk_cnt_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted command always takes the sequencer out of idle in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("sequencer idle right after a command transfer");

  // an empty list keeps head at zero
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0))
    else $error("head nonzero while list is empty");

  // the node being linked in was not a member yet
  a_insert_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR1 && cmd_r != CMD_REMOVE) |-> !member_r[ins_node])
    else $error("linking a node that is already a member");

  // list_empty and count_now agree in every result
  a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28] == (out_tdata[19:11] == '0)))
    else $error("list_empty disagrees with count_now");

endmodule
